// File: hw/rtl/clcp_pkg.sv
// Shared types, constants and per-character helper functions for the CAN log line parser.
`default_nettype none

package clcp_pkg;

    localparam int HeaderLen = 54;
    localparam logic [HeaderLen*8-1:0] HeaderText =
        "Time Stamp,ID,Extended,Bus,LEN,D1,D2,D3,D4,D5,D6,D7,D8";

    localparam logic [7:0] ChCr    = 8'h0d;
    localparam logic [7:0] ChLf    = 8'h0a;
    localparam logic [7:0] ChComma = 8'h2c;

    localparam int MetaColumns     = 5;
    localparam int MaxPayloadBytes = 8;
    localparam logic [3:0] ColumnSat = 4'd15;
    localparam logic [4:0] TokenDead = 5'd31;
    localparam logic [31:0] StdIdMax = 32'h0000_07ff;
    localparam logic [31:0] ExtIdMax = 32'h1fff_ffff;

    localparam int FifoDepth = 8;
    localparam int FifoAw    = 3;

    // Result kinds
    localparam logic [1:0] KindFrame = 2'd0;
    localparam logic [1:0] KindError = 2'd1;
    localparam logic [1:0] KindDone  = 2'd2;

    // Error codes
    localparam logic [3:0] ErrBadHeader    = 4'd0;
    localparam logic [3:0] ErrEmptyRow     = 4'd1;
    localparam logic [3:0] ErrFewColumns   = 4'd2;
    localparam logic [3:0] ErrTimestamp    = 4'd3;
    localparam logic [3:0] ErrIdentifier   = 4'd4;
    localparam logic [3:0] ErrExtended     = 4'd5;
    localparam logic [3:0] ErrBus          = 4'd6;
    localparam logic [3:0] ErrBusRange     = 4'd7;
    localparam logic [3:0] ErrDlc          = 4'd8;
    localparam logic [3:0] ErrExtraColumns = 4'd9;
    localparam logic [3:0] ErrMissingByte  = 4'd10;
    localparam logic [3:0] ErrBadByte      = 4'd11;
    localparam logic [3:0] ErrRange        = 4'd12;
    localparam logic [3:0] ErrNoHeader     = 4'd13;

    // Field bad flag positions
    localparam int FlagTime = 0;
    localparam int FlagId   = 1;
    localparam int FlagBus  = 3;
    localparam int FlagLen  = 4;

    typedef struct packed {
        logic        has_chars;
        logic        pending_cr;
        logic [5:0]  hdr_pos;
        logic        hdr_mis;
        logic [3:0]  col;
        logic [1:0]  clen;
        logic [63:0] tacc;
        logic [31:0] iacc;
        logic [31:0] bacc;
        logic [31:0] lacc;
        logic [4:0]  tok;
        logic [4:0]  fbad;
        logic [MaxPayloadBytes-1:0][7:0] pbytes;
        logic [MaxPayloadBytes-1:0]      pbad;
    } t_line_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic        final_res;
        logic [3:0]  error_code;
        logic [31:0] line_num;
        logic [63:0] stamp_us;
        logic [28:0] identifier;
        logic        extended;
        logic [7:0]  bus;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } t_result;

    typedef struct packed {
        logic    emit;
        logic    is_err;
        logic    hdr_ok;
        t_result res;
    } t_verdict;

    function automatic logic [7:0] header_char(logic [5:0] pos);
        int idx;
        idx = HeaderLen - 1 - int'(pos);
        if (idx < 0) begin
            idx = 0;
        end
        return HeaderText[idx*8 +: 8];
    endfunction

    // Returns {valid, nibble}
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

    // Returns {overflow_or_bad, new_acc}
    function automatic logic [32:0] dec32_step(logic [31:0] acc, logic [7:0] c);
        logic [35:0] w;
        logic [32:0] r;
        w = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 36'(c - "0");
        r = {1'b0, acc};
        if (c < "0" || c > "9") begin
            r[32] = 1'b1;
        end else if (|w[35:32]) begin
            r[32] = 1'b1;
        end else begin
            r[31:0] = w[31:0];
        end
        return r;
    endfunction

    function automatic logic [4:0] token_next(logic [4:0] st, logic [7:0] c);
        logic [4:0] nx;
        nx = TokenDead;
        case (st)
            5'd0: begin
                if (c == "0") nx = 5'd1;
                else if (c == "1") nx = 5'd2;
                else if (c == "f") nx = 5'd3;
                else if (c == "F") nx = 5'd8;
                else if (c == "t") nx = 5'd17;
                else if (c == "T") nx = 5'd21;
            end
            5'd3:  if (c == "a") nx = 5'd4;
            5'd4:  if (c == "l") nx = 5'd5;
            5'd5:  if (c == "s") nx = 5'd6;
            5'd6:  if (c == "e") nx = 5'd7;
            5'd8: begin
                if (c == "a") nx = 5'd9;
                else if (c == "A") nx = 5'd13;
            end
            5'd9:  if (c == "l") nx = 5'd10;
            5'd10: if (c == "s") nx = 5'd11;
            5'd11: if (c == "e") nx = 5'd12;
            5'd13: if (c == "L") nx = 5'd14;
            5'd14: if (c == "S") nx = 5'd15;
            5'd15: if (c == "E") nx = 5'd16;
            5'd17: if (c == "r") nx = 5'd18;
            5'd18: if (c == "u") nx = 5'd19;
            5'd19: if (c == "e") nx = 5'd20;
            5'd21: begin
                if (c == "r") nx = 5'd22;
                else if (c == "R") nx = 5'd25;
            end
            5'd22: if (c == "u") nx = 5'd23;
            5'd23: if (c == "e") nx = 5'd24;
            5'd25: if (c == "U") nx = 5'd26;
            5'd26: if (c == "E") nx = 5'd27;
            default: nx = TokenDead;
        endcase
        return nx;
    endfunction

    // Advance the column state by one character of a data line
    function automatic t_line_state feed_field(t_line_state s, logic [7:0] c,
                                               logic [3:0] npb);
        t_line_state n;
        logic [4:0]  lim;
        logic [2:0]  p;
        logic [1:0]  prior;
        logic [67:0] tw;
        logic [4:0]  hv;
        logic [32:0] dr;
        n     = s;
        lim   = 5'(MetaColumns) + 5'(npb);
        p     = 3'(s.col - 4'(MetaColumns));
        prior = s.clen;
        tw    = ({4'b0, s.tacc} << 3) + ({4'b0, s.tacc} << 1) + 68'(c - "0");
        hv    = hex_value(c);
        dr    = '0;
        if (c == ChComma) begin
            if (s.col >= 4'(MetaColumns) && {1'b0, s.col} < lim &&
                (s.clen == 2'd0 || s.clen == 2'd3)) begin
                n.pbad[p] = 1'b1;
            end
            if (s.col < 4'(MetaColumns) && s.col != 4'd2 && s.clen == 2'd0) begin
                n.fbad[s.col[2:0]] = 1'b1;
            end
            if (s.col < ColumnSat) begin
                n.col = s.col + 4'd1;
            end
            n.clen = 2'd0;
        end else begin
            if (s.clen < 2'd3) begin
                n.clen = s.clen + 2'd1;
            end
            case (s.col)
                4'd0: begin
                    if (!s.fbad[FlagTime]) begin
                        if (c < "0" || c > "9" || (|tw[67:64])) begin
                            n.fbad[FlagTime] = 1'b1;
                        end else begin
                            n.tacc = tw[63:0];
                        end
                    end
                end
                4'd1: begin
                    if (!s.fbad[FlagId]) begin
                        if (!hv[4] || (|s.iacc[31:28])) begin
                            n.fbad[FlagId] = 1'b1;
                        end else begin
                            n.iacc = {s.iacc[27:0], hv[3:0]};
                        end
                    end
                end
                4'd2: n.tok = token_next(s.tok, c);
                4'd3: begin
                    if (!s.fbad[FlagBus]) begin
                        dr = dec32_step(s.bacc, c);
                        n.fbad[FlagBus] = dr[32];
                        n.bacc = dr[31:0];
                    end
                end
                4'd4: begin
                    if (!s.fbad[FlagLen]) begin
                        dr = dec32_step(s.lacc, c);
                        n.fbad[FlagLen] = dr[32];
                        n.lacc = dr[31:0];
                    end
                end
                default: begin
                    if ({1'b0, s.col} < lim) begin
                        if (!hv[4]) begin
                            n.pbad[p] = 1'b1;
                        end else if (prior < 2'd2) begin
                            n.pbytes[p] = {s.pbytes[p][3:0], hv[3:0]};
                        end
                    end
                end
            endcase
        end
        return n;
    endfunction

    // Route one character to the header matcher or the column parser
    function automatic t_line_state feed_char(t_line_state s, logic [7:0] c,
                                              logic hdr_seen, logic [3:0] npb);
        t_line_state n;
        n = s;
        if (!hdr_seen) begin
            if (int'(s.hdr_pos) < HeaderLen && c == header_char(s.hdr_pos)) begin
                n.hdr_pos = s.hdr_pos + 6'd1;
            end else begin
                n.hdr_mis = 1'b1;
            end
        end else begin
            n = feed_field(s, c, npb);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/clcp_stream_if.sv
// Valid/ready channel interfaces for the character input and the result output.
`default_nettype none

interface clcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       finish;

    modport source (output valid, output symbol, output finish, input ready);
    modport sink   (input valid, input symbol, input finish, output ready);
endinterface

interface clcp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        final_res;
    logic [3:0]  error_code;
    logic [31:0] line_num;
    logic [63:0] stamp_us;
    logic [28:0] identifier;
    logic        extended;
    logic [7:0]  bus;
    logic [3:0]  dlc;
    logic [63:0] payload;

    modport source (output valid, output kind, output final_res, output error_code,
                    output line_num, output stamp_us, output identifier,
                    output extended, output bus, output dlc, output payload,
                    input ready);
    modport sink   (input valid, input kind, input final_res, input error_code,
                    input line_num, input stamp_us, input identifier,
                    input extended, input bus, input dlc, input payload,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/can_log_csv_line_parser.sv
// A character transfer is registered, evaluated from that register, and its result is
// written to the result buffer, whose head drives the output. Throughput: one character
// per cycle while input is not stalled; the line state update is one registered pass.
// A finish item may give two results, queued in an eight-entry result buffer; input
// stalls when the buffer could not take two more results beyond those of the held item.
// Reset (synchronous, active low) clears line state and queue; the line count restarts at 1.
`default_nettype none

module can_log_csv_line_parser #(
    parameter int PAYLOAD_BYTES   = 8,
    parameter int LINE_COUNT_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clcp_in_if.sink           i_in,
    clcp_out_if.source        o_out
);

    logic                       r_in_v;
    logic [7:0]                 r_sym;
    logic                       r_fin;
    clcp_pkg::t_line_state      r_st, n_st, w_step;
    logic                       r_hdr, n_hdr;
    logic                       r_halted, n_halted;
    logic [LINE_COUNT_BITS-1:0] r_line, n_line;
    logic [63:0]                w_line_wide;
    logic [31:0]                w_line32;
    clcp_pkg::t_verdict         w_vd;
    clcp_pkg::t_result          w_res_a, w_res_b, w_tail, w_head;
    logic [1:0]                 w_push_n;
    logic [clcp_pkg::FifoAw:0]  w_cnt;
    logic                       w_pop;
    logic                       w_fail_now;

    // accept input while the queue has room for this and the held item
    assign i_in.ready = (5'(w_cnt) + (r_in_v ? 5'd2 : 5'd0)) <= 5'(clcp_pkg::FifoDepth - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= i_in.valid && i_in.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sym <= i_in.symbol;
            r_fin <= i_in.finish;
        end
    end

    // saturate the line number to the port width
    assign w_line_wide = 64'(r_line);
    assign w_line32    = (|w_line_wide[63:32]) ? 32'hffff_ffff : w_line_wide[31:0];

    clcp_char_step #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_step (
        .i_state    (r_st),
        .i_symbol   (r_sym),
        .i_hdr_seen (r_hdr),
        .o_state    (w_step)
    );

    clcp_line_check #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_check (
        .i_state    (r_st),
        .i_hdr_seen (r_hdr),
        .i_line     (w_line32),
        .o_verdict  (w_vd)
    );

    // next state and results for the held item
    always_comb begin
        n_st     = r_st;
        n_hdr    = r_hdr;
        n_halted = r_halted;
        n_line   = r_line;
        w_res_a  = w_vd.res;
        w_res_b  = '0;
        w_tail   = '0;
        w_push_n = 2'd0;
        w_fail_now = r_st.has_chars && w_vd.is_err;
        if (r_in_v) begin
            if (r_fin) begin
                if (!r_halted) begin
                    if (r_hdr || (r_st.has_chars && w_vd.hdr_ok)) begin
                        w_tail.kind      = clcp_pkg::KindDone;
                        w_tail.final_res = 1'b1;
                    end else begin
                        w_tail.kind        = clcp_pkg::KindError;
                        w_tail.final_res   = 1'b1;
                        w_tail.error_code  = clcp_pkg::ErrNoHeader;
                        w_tail.line_num    = 32'd1;
                    end
                    if (r_st.has_chars && w_vd.emit) begin
                        w_res_b  = w_tail;
                        w_push_n = w_fail_now ? 2'd1 : 2'd2;
                    end else begin
                        w_res_a  = w_tail;
                        w_push_n = 2'd1;
                    end
                end
                // rearm for a new text
                n_st     = '0;
                n_hdr    = 1'b0;
                n_halted = 1'b0;
                n_line   = LINE_COUNT_BITS'(1);
            end else if (!r_halted) begin
                if (r_sym == clcp_pkg::ChLf) begin
                    w_push_n = w_vd.emit ? 2'd1 : 2'd0;
                    if (w_vd.is_err) begin
                        n_halted = 1'b1;
                    end else begin
                        if (r_line != '1) begin
                            n_line = r_line + 1'b1;
                        end
                        n_st  = '0;
                        n_hdr = r_hdr || w_vd.hdr_ok;
                    end
                end else begin
                    n_st = w_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '0;
            r_hdr    <= 1'b0;
            r_halted <= 1'b0;
            r_line   <= LINE_COUNT_BITS'(1);
        end else begin
            r_st     <= n_st;
            r_hdr    <= n_hdr;
            r_halted <= n_halted;
            r_line   <= n_line;
        end
    end

    assign w_pop = o_out.valid && o_out.ready;

    clcp_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res_a  (w_res_a),
        .i_res_b  (w_res_b),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_count  (w_cnt)
    );

    // drive the result channel from the queue head
    assign o_out.valid        = (w_cnt != '0);
    assign o_out.kind         = w_head.kind;
    assign o_out.final_res    = w_head.final_res;
    assign o_out.error_code   = w_head.error_code;
    assign o_out.line_num     = w_head.line_num;
    assign o_out.stamp_us     = w_head.stamp_us;
    assign o_out.identifier   = w_head.identifier;
    assign o_out.extended     = w_head.extended;
    assign o_out.bus          = w_head.bus;
    assign o_out.dlc          = w_head.dlc;
    assign o_out.payload      = w_head.payload;

    // queue never takes more than it can hold
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n != 2'd0) |-> ((5'(w_cnt) + 5'(w_push_n)) <= 5'(clcp_pkg::FifoDepth)))
        else $error("result queue overflow");

    // halted parser gives no result for characters
    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !r_fin && r_halted) |-> (w_push_n == 2'd0))
        else $error("result after error");

    // an error on a line end halts the parser
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !r_fin && !r_halted && r_sym == clcp_pkg::ChLf && w_vd.is_err)
        |=> r_halted)
        else $error("error did not halt");

    // finish rearms the parser
    a_finish_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && r_fin) |=> (!r_hdr && !r_halted && r_line == LINE_COUNT_BITS'(1)))
        else $error("finish did not rearm");

endmodule

`default_nettype wire

// File: hw/rtl/clcp_char_step.sv
// Per-character update of the line state: carriage return hold-back, header match, columns.
`default_nettype none

module clcp_char_step #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  clcp_pkg::t_line_state i_state,
    input  logic [7:0]            i_symbol,
    input  logic                  i_hdr_seen,
    output clcp_pkg::t_line_state o_state
);

    localparam logic [3:0] Npb = 4'(PAYLOAD_BYTES);

    clcp_pkg::t_line_state w_s;

    always_comb begin
        w_s = i_state;
        w_s.has_chars  = 1'b1;
        w_s.pending_cr = 1'b0;
        // release a held carriage return as an ordinary character
        if (i_state.pending_cr) begin
            w_s = clcp_pkg::feed_char(w_s, clcp_pkg::ChCr, i_hdr_seen, Npb);
        end
        // hold a new carriage return until the next character shows its role
        if (i_symbol == clcp_pkg::ChCr) begin
            w_s.pending_cr = 1'b1;
        end else begin
            w_s = clcp_pkg::feed_char(w_s, i_symbol, i_hdr_seen, Npb);
        end
    end

    assign o_state = w_s;

endmodule

`default_nettype wire

// File: hw/rtl/clcp_line_check.sv
// End-of-line evaluation: header acceptance or frame checks in priority order.
`default_nettype none

module clcp_line_check #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  clcp_pkg::t_line_state i_state,
    input  logic                  i_hdr_seen,
    input  logic [31:0]           i_line,
    output clcp_pkg::t_verdict    o_verdict
);

    localparam logic [3:0] Npb = 4'(PAYLOAD_BYTES);

    clcp_pkg::t_line_state w_f;
    logic [3:0]  w_col;
    logic [4:0]  w_count;
    logic        w_ext_ok;
    logic        w_ext;
    logic [3:0]  w_dlc;
    logic [clcp_pkg::MaxPayloadBytes-1:0] w_mask;
    logic [63:0] w_pay;
    logic [3:0]  w_code;
    logic        w_err;

    // close the last column as if a comma followed
    always_comb begin
        w_f   = clcp_pkg::feed_field(i_state, clcp_pkg::ChComma, Npb);
        w_col = w_f.col - 4'd1;
        if (w_col == 4'd14) begin
            w_col = 4'd15;
        end
        w_count = {1'b0, w_col} + 5'd1;
    end

    // decode the extended token
    always_comb begin
        w_ext_ok = 1'b1;
        w_ext    = 1'b0;
        case (w_f.tok)
            5'd1, 5'd7, 5'd12, 5'd16: w_ext = 1'b0;
            5'd2, 5'd20, 5'd24, 5'd27: w_ext = 1'b1;
            default: w_ext_ok = 1'b0;
        endcase
    end

    // gather payload bytes below the length
    always_comb begin
        w_dlc = w_f.lacc[3:0];
        w_pay = '0;
        for (int i = 0; i < clcp_pkg::MaxPayloadBytes; i++) begin
            w_mask[i] = (4'(i) < w_dlc);
            w_pay[i*8 +: 8] = w_mask[i] ? w_f.pbytes[i] : 8'h00;
        end
    end

    // pick the first failing check
    always_comb begin
        w_err  = 1'b1;
        w_code = clcp_pkg::ErrBadHeader;
        if (!i_hdr_seen) begin
            w_err = i_state.hdr_mis || (int'(i_state.hdr_pos) != clcp_pkg::HeaderLen);
        end else if (i_state.col == 4'd0 && i_state.clen == 2'd0) begin
            w_code = clcp_pkg::ErrEmptyRow;
        end else if (w_count < 5'(clcp_pkg::MetaColumns)) begin
            w_code = clcp_pkg::ErrFewColumns;
        end else if (w_f.fbad[clcp_pkg::FlagTime]) begin
            w_code = clcp_pkg::ErrTimestamp;
        end else if (w_f.fbad[clcp_pkg::FlagId]) begin
            w_code = clcp_pkg::ErrIdentifier;
        end else if (!w_ext_ok) begin
            w_code = clcp_pkg::ErrExtended;
        end else if (w_f.fbad[clcp_pkg::FlagBus]) begin
            w_code = clcp_pkg::ErrBus;
        end else if (|w_f.bacc[31:8]) begin
            w_code = clcp_pkg::ErrBusRange;
        end else if (w_f.fbad[clcp_pkg::FlagLen] || w_f.lacc > 32'(Npb)) begin
            w_code = clcp_pkg::ErrDlc;
        end else if (w_count > 5'(clcp_pkg::MetaColumns) + 5'(Npb)) begin
            w_code = clcp_pkg::ErrExtraColumns;
        end else if (w_count < 5'(clcp_pkg::MetaColumns) + 5'(w_dlc)) begin
            w_code = clcp_pkg::ErrMissingByte;
        end else if (|(w_f.pbad & w_mask)) begin
            w_code = clcp_pkg::ErrBadByte;
        end else if (w_f.iacc > (w_ext ? clcp_pkg::ExtIdMax : clcp_pkg::StdIdMax)) begin
            w_code = clcp_pkg::ErrRange;
        end else begin
            w_err = 1'b0;
        end
    end

    // build the result
    always_comb begin
        o_verdict = '0;
        o_verdict.is_err = w_err;
        o_verdict.hdr_ok = !i_hdr_seen && !w_err;
        o_verdict.emit   = w_err || i_hdr_seen;
        o_verdict.res.line_num = i_line;
        if (w_err) begin
            o_verdict.res.kind       = clcp_pkg::KindError;
            o_verdict.res.final_res  = 1'b1;
            o_verdict.res.error_code = w_code;
        end else begin
            o_verdict.res.kind         = clcp_pkg::KindFrame;
            o_verdict.res.stamp_us     = w_f.tacc;
            o_verdict.res.identifier   = w_f.iacc[28:0];
            o_verdict.res.extended     = w_ext;
            o_verdict.res.bus          = w_f.bacc[7:0];
            o_verdict.res.dlc          = w_dlc;
            o_verdict.res.payload      = w_pay;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/clcp_result_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
`default_nettype none

module clcp_result_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_n,
    input  clcp_pkg::t_result     i_res_a,
    input  clcp_pkg::t_result     i_res_b,
    input  logic                  i_pop,
    output clcp_pkg::t_result     o_head,
    output logic [clcp_pkg::FifoAw:0] o_count
);

    clcp_pkg::t_result r_mem [clcp_pkg::FifoDepth];
    logic [clcp_pkg::FifoAw-1:0] r_wr, r_rd;
    logic [clcp_pkg::FifoAw:0]   r_cnt;
    logic [clcp_pkg::FifoAw-1:0] w_wr1;

    assign w_wr1 = r_wr + 1'b1;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + clcp_pkg::FifoAw'(i_push_n);
            r_rd  <= r_rd + clcp_pkg::FifoAw'(i_pop);
            r_cnt <= r_cnt + (clcp_pkg::FifoAw+1)'(i_push_n)
                           - (clcp_pkg::FifoAw+1)'(i_pop);
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_res_a;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr1] <= i_res_b;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

`default_nettype wire
